[rtl/core/wngc_pkg.sv]
`timescale 1ns / 1ps

package wngc_pkg;

    // Item operation codes, carried in s_tuser
    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_WRITE    = 3'd1,
        OP_FREEZE   = 3'd2,
        OP_UNFREEZE = 3'd3,
        OP_SLEEP    = 3'd4
    } wngc_op_t;

    // Per-item event flags from the update logic
    typedef struct packed {
        logic nmi_pulse;
        logic chip_reset;
        logic write_taken;
    } wngc_flags_t;

    localparam int OP_BITS   = 3;
    localparam int DATA_BITS = 32;

endpackage

[rtl/core/wngc_update.sv]
`timescale 1ns / 1ps

module wngc_update
    import wngc_pkg::*;
#(
    parameter int COUNT_BITS  = 13,
    parameter int GRACE_TICKS = 16,
    parameter int CW          = 14
)
(
    input  logic                   mode_reset,
    input  logic                   hold,
    input  logic signed [CW-1:0]   count,
    input  logic [OP_BITS-1:0]     op,
    input  logic [DATA_BITS-1:0]   data,
    output logic signed [CW-1:0]   count_next,
    output logic                   hold_next,
    output wngc_flags_t            flags
);

    localparam int GRACE_NEG_I = -GRACE_TICKS;
    localparam logic signed [CW-1:0] GRACE_NEG = CW'(GRACE_NEG_I);

    logic signed [CW-1:0] count_dec;
    logic                 count_pos;
    logic                 write_ok;

    assign count_dec = count - CW'(1);
    assign count_pos = !count[CW-1] && (count != '0);
    // guard bits: everything above bit COUNT_BITS must be clear
    assign write_ok  = ((data >> (COUNT_BITS + 1)) == '0);

    // Next state and events for one item
    always_comb
    begin
        count_next = count;
        hold_next  = hold;
        flags      = '0;
        case (wngc_op_t'(op))
            OP_TICK:
            begin
                if (!hold)
                begin
                    if (count_pos)
                    begin
                        count_next = count_dec;
                        if (count_dec == '0)
                        begin
                            flags.chip_reset = mode_reset;
                            flags.nmi_pulse  = !mode_reset;
                        end
                    end
                    else if (mode_reset)
                    begin
                        flags.chip_reset = 1'b1;
                    end
                    else if (count > GRACE_NEG)
                    begin
                        count_next       = count_dec;
                        flags.chip_reset = (count_dec <= GRACE_NEG);
                    end
                    else
                    begin
                        // past the reset point: stay, reset again
                        flags.chip_reset = 1'b1;
                    end
                end
            end
            OP_WRITE:
            begin
                if (write_ok)
                begin
                    count_next = {{(CW - COUNT_BITS){1'b0}}, data[COUNT_BITS-1:0]};
                    flags.write_taken = 1'b1;
                end
            end
            OP_FREEZE:
            begin
                hold_next = 1'b1;
            end
            OP_UNFREEZE, OP_SLEEP:
            begin
                hold_next = 1'b0;
            end
            default:
            begin
                count_next = count;
            end
        endcase
    end

endmodule

[rtl/core/watchdog_nmi_grace_counter_top.sv]
`timescale 1ns / 1ps
// An accepted item is held in the input register; its result is registered into
// the result register and shown on m_tdata once that register is free.
// Throughput: one item per clock unless m_tready stalls the result register; the counter
// update is a single decrement and compare between the input and result registers.
// Reset (rst_n low, asynchronous): count at its maximum reload, hold clear,
// reset-at-zero mode selected, both stages empty.

module watchdog_nmi_grace_counter_top
    import wngc_pkg::*;
#(
    parameter int COUNT_BITS  = 13,
    parameter int GRACE_TICKS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration: bit 0 reset_at_zero_mode
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: write_data[31:0]
    input  logic [DATA_BITS-1:0] s_tdata,
    // s_tuser: op[2:0]
    input  logic [OP_BITS-1:0]   s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: count_now[COUNT_BITS:0], count_negative, nmi_pulse,
    //          chip_reset, write_taken, frozen_now, zero fill
    output logic [((COUNT_BITS + 6 + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int GB  = $clog2(GRACE_TICKS + 1);
    localparam int CW  = ((COUNT_BITS > GB) ? COUNT_BITS : GB) + 1;
    localparam int OUT_BITS = COUNT_BITS + 6;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int GRACE_NEG_I = -GRACE_TICKS;
    localparam logic signed [CW-1:0] GRACE_NEG = CW'(GRACE_NEG_I);
    localparam logic signed [CW-1:0] COUNT_MAX =
        {{(CW - COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

    logic                  in_valid_reg;
    logic [OP_BITS-1:0]    in_op_reg;
    logic [DATA_BITS-1:0]  in_data_reg;

    logic signed [CW-1:0]  count_reg;
    logic signed [CW-1:0]  count_next;
    logic                  hold_reg;
    logic                  hold_next;
    logic                  mode_reg;
    wngc_flags_t           flags;

    logic                  m_valid_reg;
    logic [COUNT_BITS:0]   m_count_reg;
    logic                  m_neg_reg;
    wngc_flags_t           m_flags_reg;
    logic                  m_frozen_reg;

    logic                  advance;

    // Handshake: input stage moves on whenever the result register is free
    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = OUT_W'({m_frozen_reg, m_flags_reg.write_taken,
                               m_flags_reg.chip_reset, m_flags_reg.nmi_pulse,
                               m_neg_reg, m_count_reg});

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    // Counter update logic
    wngc_update #(
        .COUNT_BITS  (COUNT_BITS),
        .GRACE_TICKS (GRACE_TICKS),
        .CW          (CW)
    ) u_update (
        .mode_reset (mode_reg),
        .hold       (hold_reg),
        .count      (count_reg),
        .op         (in_op_reg),
        .data       (in_data_reg),
        .count_next (count_next),
        .hold_next  (hold_next),
        .flags      (flags)
    );

    // Watchdog state and mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_MAX;
            hold_reg  <= 1'b0;
            mode_reg  <= 1'b1;
        end
        else
        begin
            if (advance)
            begin
                count_reg <= count_next;
                hold_reg  <= hold_next;
            end
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_count_reg  <= count_next[COUNT_BITS:0];
            m_neg_reg    <= count_next[CW-1];
            m_flags_reg  <= flags;
            m_frozen_reg <= hold_next;
        end
    end

`ifndef SYNTHESIS
    // NMI and chip reset never come from the same tick
    a_nmi_rst_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(m_flags_reg.nmi_pulse && m_flags_reg.chip_reset))
        else $error("nmi_pulse and chip_reset raised together");

    // an NMI is only raised as the count lands on zero
    a_nmi_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_flags_reg.nmi_pulse) |-> (m_count_reg == '0))
        else $error("nmi_pulse with non-zero count");

    // a taken write always leaves a non-negative count
    a_write_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_flags_reg.write_taken) |-> !m_neg_reg)
        else $error("write taken but count negative");

    // the count never runs below the grace limit
    a_grace_floor: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> (count_reg >= GRACE_NEG))
        else $error("count below grace limit");

    // a stalled result keeps the waiting item in the input register
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && m_valid_reg && !m_tready) |=> in_valid_reg)
        else $error("input item lost under stall");
`endif

endmodule
